### src/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared constants, codes and types of the four-queue round-robin drain unit.
// ----------------------------------------------------------------------------
package rrd_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int TAG_WIDTH   = 32;
	localparam int NUM_QUEUES  = 4;

	localparam int QSEL_W  = $clog2(NUM_QUEUES);
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = QSEL_W + PTR_W;
	localparam int MEM_DEPTH = NUM_QUEUES << PTR_W;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	typedef enum logic [1:0] {
		ST_DELIVERED    = 2'd0,
		ST_PUSHED       = 2'd1,
		ST_DROPPED      = 2'd2,
		ST_NONE_WAITING = 2'd3
	} status_t;

	typedef logic [QSEL_W-1:0]    qsel_t;
	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [TAG_WIDTH-1:0] tag_t;

	// access request from the queue control to the tag memory
	typedef struct packed {
		logic  wr_en;
		addr_t wr_addr;
		logic  rd_en;
		addr_t rd_addr;
	} mem_req_t;

	// wrap a queue index modulo the queue depth
	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

### src/rrd_if.sv
// ----------------------------------------------------------------------------
// rrd_if
// Valid/ready channels: command items in, result items out.
// ----------------------------------------------------------------------------
interface rrd_cmd_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [1:0]  queue_sel;
	logic [31:0] plane_tag;

	modport source (output valid, cmd, queue_sel, plane_tag, input ready);
	modport sink   (input valid, cmd, queue_sel, plane_tag, output ready);
endinterface

interface rrd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_tag;
	logic [1:0]  from_queue;
	logic        all_empty;

	modport source (output valid, status, out_tag, from_queue, all_empty, input ready);
	modport sink   (input valid, status, out_tag, from_queue, all_empty, output ready);
endinterface

### src/rrd_tag_ram.sv
// ----------------------------------------------------------------------------
// rrd_tag_ram
// Tag storage, one region per queue; one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module rrd_tag_ram (
	input  logic              clk,
	input  rrd_pkg::mem_req_t req,
	input  rrd_pkg::tag_t     wr_data,
	output rrd_pkg::tag_t     rd_data
);
	import rrd_pkg::*;

	tag_t mem [MEM_DEPTH];
	tag_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/rrd_ctrl.sv
// ----------------------------------------------------------------------------
// rrd_ctrl
// Queue pointers, fill counts and the round-robin pick; registers the status
// side of each result.
// ----------------------------------------------------------------------------
module rrd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               cmd,
	input  rrd_pkg::qsel_t     queue_sel,
	output rrd_pkg::mem_req_t  mem_req,
	output rrd_pkg::status_t   status,
	output rrd_pkg::qsel_t     from_queue,
	output logic               all_empty
);
	import rrd_pkg::*;

	ptr_t    head_q [NUM_QUEUES];
	ptr_t    tail_q [NUM_QUEUES];
	cnt_t    count_q [NUM_QUEUES];
	qsel_t   next_q;
	status_t status_q;
	qsel_t   from_q;
	logic    empty_q;

	cnt_t    count_nxt [NUM_QUEUES];
	logic    found;
	qsel_t   pick;
	qsel_t   scan;
	logic    full;
	logic    do_push;
	logic    do_pull;
	logic    empty_nxt;
	qsel_t   next_nxt;
	status_t status_nxt;
	qsel_t   from_nxt;

	// first non-empty queue from the round-robin start
	always_comb begin
		found = 1'b0;
		pick  = '0;
		scan  = '0;
		for (int k = 0; k < NUM_QUEUES; k++) begin
			scan = next_q + QSEL_W'(k);
			if (!found && count_q[scan] != '0) begin
				found = 1'b1;
				pick  = scan;
			end
		end
	end

	assign full    = (count_q[queue_sel] >= CNT_W'(QUEUE_DEPTH));
	assign do_push = accept && (cmd == CMD_PUSH) && !full;
	assign do_pull = accept && (cmd == CMD_PULL) && found;

	always_comb begin
		empty_nxt = 1'b1;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			count_nxt[i] = count_q[i];
			if (do_push && queue_sel == QSEL_W'(i)) begin
				count_nxt[i] = count_q[i] + 1'b1;
			end
			if (do_pull && pick == QSEL_W'(i)) begin
				count_nxt[i] = count_q[i] - 1'b1;
			end
			if (count_nxt[i] != '0) begin
				empty_nxt = 1'b0;
			end
		end
	end

	always_comb begin
		next_nxt = next_q;
		if (do_pull) begin
			next_nxt = pick + 1'b1;
		end
		if (empty_nxt) begin
			next_nxt = '0;
		end
	end

	always_comb begin
		if (cmd == CMD_PUSH) begin
			status_nxt = full ? ST_DROPPED : ST_PUSHED;
			from_nxt   = queue_sel;
		end else begin
			status_nxt = found ? ST_DELIVERED : ST_NONE_WAITING;
			from_nxt   = found ? pick : '0;
		end
	end

	always_comb begin
		mem_req.wr_en   = do_push;
		mem_req.wr_addr = {queue_sel, tail_q[queue_sel]};
		mem_req.rd_en   = do_pull;
		mem_req.rd_addr = {pick, head_q[pick]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			next_q   <= '0;
			status_q <= ST_NONE_WAITING;
			from_q   <= '0;
			empty_q  <= 1'b1;
		end else if (accept) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				count_q[i] <= count_nxt[i];
			end
			if (do_push) begin
				tail_q[queue_sel] <= ptr_inc(tail_q[queue_sel]);
			end
			if (do_pull) begin
				head_q[pick] <= ptr_inc(head_q[pick]);
			end
			next_q   <= next_nxt;
			status_q <= status_nxt;
			from_q   <= from_nxt;
			empty_q  <= empty_nxt;
		end
	end

	assign status     = status_q;
	assign from_queue = from_q;
	assign all_empty  = empty_q;

endmodule

### src/four_queue_round_robin_drain_unit.sv
// ----------------------------------------------------------------------------
// four_queue_round_robin_drain_unit
// Four tag queues (west, north, south, east) drained round-robin by pull items.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    cmd, queue_sel, plane_tag
//  out_ch    out   valid/ready    status, out_tag, from_queue, all_empty
//
//  one item per cycle unless a result is held back; each result appears in the
//  cycle after its item is taken, held in the rrd_ctrl status registers and
//  the tag memory read register. the input stalls only while a result waits
//  and out_ch is not ready; pointer update and round-robin pick finish in the
//  accept cycle. after reset all queues are empty and the scan starts at west;
//  the tag memory needs no clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
module four_queue_round_robin_drain_unit (
	input  logic clk,
	input  logic arst_n,
	rrd_cmd_if.sink   in_ch,
	rrd_res_if.source out_ch
);
	import rrd_pkg::*;

	logic     out_valid_q;
	logic     accept;
	mem_req_t mem_req;
	tag_t     rd_data;
	status_t  status;
	qsel_t    from_queue;
	logic     all_empty;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	rrd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (in_ch.cmd),
		.queue_sel  (QSEL_W'(in_ch.queue_sel)),
		.mem_req    (mem_req),
		.status     (status),
		.from_queue (from_queue),
		.all_empty  (all_empty)
	);

	rrd_tag_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.wr_data (TAG_WIDTH'(in_ch.plane_tag)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = status;
	// read data only means something for a delivered tag
	assign out_ch.out_tag    = (status == ST_DELIVERED) ? 32'(rd_data) : 32'd0;
	assign out_ch.from_queue = 2'(from_queue);
	assign out_ch.all_empty  = all_empty;

endmodule
